// ----- hw/rtl/smx_pkg.sv -----
// Package for softmax_vector: payload structs, state enum, exp constants and table.
// No dependencies.
package smx_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned ProbW   = 16;
    localparam int unsigned ExpW    = 17;
    localparam int unsigned DivW    = ExpW + 16;
    localparam logic [16:0] Log2eQ16 = 17'd94548;
    localparam logic [15:0] Ln2Q16   = 16'd45426;
    localparam logic [15:0] ProbMax  = 16'hFFFF;

    typedef struct packed {
        logic [SampleW-1:0] sample_value;
        logic               is_last;
    } t_in_item;

    typedef struct packed {
        logic [ProbW-1:0] probability;
        logic             last_result;
        logic             overflow;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_E_RD,
        ST_E_MUL,
        ST_E_TAB,
        ST_E_COR,
        ST_E_WR,
        ST_N_RD,
        ST_N_LD,
        ST_N_DIV,
        ST_N_OUT
    } t_state;

    function automatic logic [16:0] pow2_frac(input logic [3:0] idx);
        logic [16:0] v;
        begin
            case (idx)
                4'd0:    v = 17'd65536;
                4'd1:    v = 17'd62757;
                4'd2:    v = 17'd60097;
                4'd3:    v = 17'd57549;
                4'd4:    v = 17'd55109;
                4'd5:    v = 17'd52773;
                4'd6:    v = 17'd50535;
                4'd7:    v = 17'd48393;
                4'd8:    v = 17'd46341;
                4'd9:    v = 17'd44376;
                4'd10:   v = 17'd42495;
                4'd11:   v = 17'd40693;
                4'd12:   v = 17'd38968;
                4'd13:   v = 17'd37316;
                4'd14:   v = 17'd35734;
                default: v = 17'd34219;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- hw/rtl/softmax_vector.sv -----
// softmax_vector top level: sample store, exp pass, restoring divider normalize pass.
// Depends on smx_pkg.
//
//  channel | signals                    | direction
//  in      | i_in_valid/o_in_ready/i_in  | samples in, valid/ready
//  out     | o_out_valid/i_out_ready/o_out | probabilities out, valid/ready
//
// Load: samples go into a store (MAX_LEN entries) with one write and one read port.
// On the last sample: exp pass steps each element through read, multiply,
// table, correct, write; then normalize steps each element through read, load,
// 33-step restoring divider, finish, advance. Input is held off meanwhile.
// Reset is synchronous, active low; the store itself is not cleared.
// A stalled output holds the next result at its finish step; nothing else advances.
module softmax_vector
    import smx_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);
    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned DCW = $clog2(DivW + 1);
    localparam int unsigned SumW = ExpW + AW;

    logic [ExpW-1:0] r_mem [MAX_LEN];
    logic [ExpW-1:0] r_rd;

    t_state r_state, n_state;
    logic signed [SampleW-1:0] r_max;
    logic [CW-1:0] r_cnt, r_idx;
    logic [SumW-1:0] r_sum;
    logic r_drop;
    // exp pipeline
    logic [SampleW:0]  r_m;
    logic [33:0]       r_u;
    logic [16:0]       r_t;
    logic [7:0]        r_lo;
    logic [4:0]        r_k;
    // divider
    logic [DivW-1:0]   r_num;
    logic [SumW:0]     r_rem;
    logic [DCW-1:0]    r_dc;
    logic [ProbW:0]    r_q;
    t_out_item         r_out;
    logic              r_ov;

    logic in_acc;
    logic [AW-1:0] idx_a, cnt_a;
    logic signed [SampleW-1:0] xs;
    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic [ExpW-1:0] mem_wd;
    logic [16:0] t2;
    logic [17:0] rnd;
    logic [ExpW-1:0] e_val;

    assign in_acc = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_LOAD);
    assign idx_a = r_idx[AW-1:0];
    assign cnt_a = r_cnt[AW-1:0];
    assign xs = signed'(i_in.sample_value);
    assign o_out_valid = r_ov;
    assign o_out = r_out;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = idx_a;
        mem_wd = e_val;
        if (in_acc && r_cnt < CW'(MAX_LEN)) begin
            mem_we = 1'b1;
            mem_wa = cnt_a;
            mem_wd = {i_in.sample_value[SampleW-1], i_in.sample_value};
        end else if (r_state == ST_E_WR) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[idx_a];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:  if (in_acc && i_in.is_last) n_state = ST_E_RD;
            ST_E_RD:  n_state = ST_E_MUL;
            ST_E_MUL: n_state = ST_E_TAB;
            ST_E_TAB: n_state = ST_E_COR;
            ST_E_COR: n_state = ST_E_WR;
            ST_E_WR:  n_state = (r_idx + 1'b1 == r_cnt) ? ST_N_RD : ST_E_RD;
            ST_N_RD:  n_state = ST_N_LD;
            ST_N_LD:  n_state = ST_N_DIV;
            ST_N_DIV: if (r_dc == '0 && !r_ov) n_state = ST_N_OUT;
            ST_N_OUT: n_state = (r_idx + 1'b1 == r_cnt) ? ST_LOAD : ST_N_RD;
            default:  n_state = ST_LOAD;
        endcase
    end

    logic [SumW:0] trial;
    logic [SumW:0] rem_sh;
    logic [50:0] corr;
    assign rem_sh = {r_rem[SumW-1:0], r_num[DivW-1]};
    assign trial = rem_sh - {1'b0, r_sum};
    assign corr = 51'(r_t) * 51'(r_lo) * 51'(Ln2Q16) + (51'd1 << 27);

    // exp value after correction and shift, written back in the write cycle
    assign t2 = r_t - 17'(corr >> 28);
    assign rnd = (r_k == 5'd0) ? {1'b0, t2} : ({1'b0, t2} + (18'd1 << (r_k - 5'd1)));
    assign e_val = (r_k > 5'd16) ? '0 : ExpW'(rnd >> r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_max <= {1'b1, {(SampleW-1){1'b0}}};
            r_cnt <= '0;
            r_idx <= '0;
            r_sum <= '0;
            r_drop <= 1'b0;
            r_ov <= 1'b0;
            r_dc <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    r_idx <= '0;
                    r_sum <= '0;
                    if (in_acc) begin
                        if (r_cnt < CW'(MAX_LEN)) begin
                            r_cnt <= r_cnt + 1'b1;
                            if (xs > r_max) r_max <= xs;
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                ST_E_RD: ;
                ST_E_MUL: begin
                    r_m <= (SampleW+1)'(r_max) - (SampleW+1)'(r_rd);
                end
                ST_E_TAB: begin
                    r_u <= (34'(r_m) * 34'(Log2eQ16) + 34'd2048) >> 12;
                end
                ST_E_COR: begin
                    r_t  <= pow2_frac(r_u[11:8]);
                    r_lo <= r_u[7:0];
                    r_k  <= (r_u[33:12] > 22'd16) ? 5'd17 : r_u[16:12];
                end
                ST_E_WR: begin
                    r_idx <= (r_idx + 1'b1 == r_cnt) ? '0 : r_idx + 1'b1;
                    r_sum <= r_sum + SumW'(e_val);
                end
                ST_N_RD: ;
                ST_N_LD: begin
                    r_dc <= DCW'(DivW);
                end
                ST_N_DIV: begin
                    if (r_dc != '0) begin
                        r_dc <= r_dc - 1'b1;
                    end
                end
                ST_N_OUT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_cnt) begin
                        r_cnt <= '0;
                        r_drop <= 1'b0;
                        r_max <= {1'b1, {(SampleW-1){1'b0}}};
                    end
                end
                default: ;
            endcase
            if (r_state == ST_N_DIV && r_dc == '0 && !r_ov) begin
                r_ov <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_N_LD) begin
            // numerator e*65536 + sum/2 shifted in MSB first
            r_num <= {r_rd, 16'd0} + DivW'(r_sum >> 1);
            r_rem <= '0;
            r_q <= '0;
        end
        if (r_state == ST_N_DIV && r_dc != '0) begin
            r_num <= {r_num[DivW-2:0], 1'b0};
            if (!trial[SumW]) begin
                r_rem <= trial;
                r_q <= {r_q[ProbW-1:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q <= {r_q[ProbW-1:0], 1'b0};
            end
        end
        if (r_state == ST_N_DIV && r_dc == '0 && !r_ov) begin
            r_out.probability <= (r_sum == '0) ? '0 : (r_q[ProbW] ? ProbMax : r_q[ProbW-1:0]);
            r_out.last_result <= (r_idx + 1'b1 == r_cnt);
            r_out.overflow <= r_drop;
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Testbench for softmax_vector: directed table, overflow, hold-off and random vectors;
// checked by an in-bench softmax predictor. Depends on smx_pkg and the RTL.
`timescale 1ns / 100ps

module testbench
    import smx_pkg::*;
();

    localparam int unsigned Depth = 64;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    softmax_vector #(.MAX_LEN(Depth)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Predictor state
    logic signed [15:0] vec_samples[Depth];
    logic signed [15:0] vec_max;
    int unsigned        vec_len;
    logic               vec_dropped;
    t_out_item          prob_queue[$];

    int  error_count;
    bit  stim_done;
    int  hold_off;   // receiver hold-off in cycles, set by the stimulus

    localparam logic [16:0] PowTab[16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219
    };

    function automatic longint unsigned exp_of_gap(longint unsigned gap);
        longint unsigned u, k, t, lo;
        u  = (gap * 94548 + 2048) >> 12;
        k  = u >> 12;
        lo = u & 255;
        t  = PowTab[(u >> 8) & 15];
        t  = t - ((t * lo * 45426 + (longint'(1) << 27)) >> 28);
        if (k > 16) return 0;
        if (k == 0) return t;
        return (t + (longint'(1) << (k - 1))) >> k;
    endfunction

    task automatic predict_sample(t_in_item it);
        longint unsigned e[Depth];
        longint unsigned sum, p;
        t_out_item r;
        if (vec_len < Depth) begin
            vec_samples[vec_len] = it.sample_value;
            vec_len++;
            if ($signed(it.sample_value) > vec_max) vec_max = it.sample_value;
        end else begin
            vec_dropped = 1'b1;
        end
        if (!it.is_last) return;
        sum = 0;
        for (int i = 0; i < vec_len; i++) begin
            e[i] = exp_of_gap(longint'(vec_max) - longint'(vec_samples[i]));
            sum += e[i];
        end
        for (int i = 0; i < vec_len; i++) begin
            p = 0;
            if (sum != 0) begin
                p = (e[i] * 65536 + sum / 2) / sum;
                if (p > 65535) p = 65535;
            end
            r.probability = p[15:0];
            r.last_result = (i + 1 == vec_len);
            r.overflow    = vec_dropped;
            prob_queue.push_back(r);
        end
        vec_max     = 16'sh8000;
        vec_len     = 0;
        vec_dropped = 1'b0;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Send one transaction, with a random gap ahead of it now and then.
    task automatic send_sample(logic [15:0] value, logic last, bit allow_gap);
        int gap;
        gap = (allow_gap && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid             <= 1'b1;
        in_item.sample_value <= value;
        in_item.is_last      <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_sample('{sample_value: value, is_last: last});
    endtask

    // Directed rows: sample and last flag; single-element vectors have an
    // obvious answer (probability saturates at 65535).
    typedef struct {
        logic [15:0] value;
        logic        last;
        logic        known;
        logic [15:0] known_prob;
    } t_row;

    localparam int NumRows = 14;
    t_row rows[NumRows];

    initial begin
        rows = '{
            '{16'h7FFF, 1'b1, 1'b1, 16'hFFFF},
            '{16'h8000, 1'b1, 1'b1, 16'hFFFF},
            '{16'h0000, 1'b1, 1'b1, 16'hFFFF},
            '{16'h7FFF, 1'b0, 1'b0, 16'h0},
            '{16'h8000, 1'b1, 1'b0, 16'h0},
            '{16'h0100, 1'b0, 1'b0, 16'h0},
            '{16'h0100, 1'b1, 1'b0, 16'h0},
            '{16'h0000, 1'b0, 1'b0, 16'h0},
            '{16'hFF00, 1'b0, 1'b0, 16'h0},
            '{16'h0A00, 1'b1, 1'b0, 16'h0},
            '{16'h5555, 1'b0, 1'b0, 16'h0},
            '{16'hAAAA, 1'b1, 1'b0, 16'h0},
            '{16'h1234, 1'b0, 1'b0, 16'h0},
            '{16'h1234, 1'b1, 1'b0, 16'h0}
        };
    end

    // Receiver: stall on its own pattern, plus one long hold-off on request.
    initial begin
        out_ready <= 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_off > 0) begin
                out_ready <= 1'b0;
                hold_off--;
            end else begin
                out_ready <= ($urandom_range(0, 9) < 7) || stim_done;
            end
        end
    end

    // Checker
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (prob_queue.size() == 0) begin
                report_mismatch("unexpected result", out_item.probability, -1);
            end else begin
                want = prob_queue.pop_front();
                if (out_item.probability !== want.probability)
                    report_mismatch("probability", out_item.probability, want.probability);
                if (out_item.last_result !== want.last_result)
                    report_mismatch("last_result", out_item.last_result, want.last_result);
                if (out_item.overflow !== want.overflow)
                    report_mismatch("overflow", out_item.overflow, want.overflow);
            end
        end
    end

    initial begin
        int len;
        logic [15:0] base, v;
        error_count = 0;
        stim_done   = 1'b0;
        hold_off    = 0;
        vec_max     = 16'sh8000;
        vec_len     = 0;
        vec_dropped = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_item     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NumRows; i++) begin
            if (rows[i].known) begin
                // Single-element vector: overwrite the prediction with the typed value.
                send_sample(rows[i].value, rows[i].last, 1'b0);
                prob_queue[prob_queue.size() - 1].probability = rows[i].known_prob;
            end else begin
                send_sample(rows[i].value, rows[i].last, 1'b1);
            end
        end

        // Overflow: 70 samples, last one dropped too; then a full store, no drop.
        for (int i = 0; i < 70; i++)
            send_sample(16'($urandom()), i == 69, 1'b1);
        for (int i = 0; i < Depth; i++)
            send_sample(16'($urandom()), i == Depth - 1, 1'b1);

        // Long receiver hold-off while the sender keeps offering.
        hold_off = 400;
        for (int i = 0; i < 12; i++)
            send_sample(16'($urandom()), (i % 4) == 3, 1'b0);

        // Random vectors: mostly short, clustered around a base so exponentials
        // stay significant; some full-range noise.
        for (int n = 0; n < 260; ) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 66) : $urandom_range(1, 8);
            base = 16'($urandom());
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 3) == 0)
                    v = 16'($urandom());
                else
                    v = base + 16'($urandom_range(0, 2047)) - 16'd1024;
                send_sample(v, i == len - 1, 1'b1);
            end
            n += len;
        end
        in_valid  <= 1'b0;
        stim_done = 1'b1;

        while (prob_queue.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Worst case: ~500 results plus stalls, well under 1 ms.
    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
